FILE: src/adll_pkg.sv
// ----------------------------------------------------------------------------
// Array doubly linked list package
// Shared widths, operation and status codes, and the structs that pass
// between the sequencer, the node store and the output stage.
// ----------------------------------------------------------------------------
package adll_pkg;

    localparam int NodeW        = 6;
    localparam int ValW         = 32;
    localparam int FuncW        = 2;
    localparam int StatW        = 2;
    localparam int PoolDepthDef = 64;

    localparam logic [FuncW-1:0] FUNC_INSERT   = 2'd0;
    localparam logic [FuncW-1:0] FUNC_ERASE    = 2'd1;
    localparam logic [FuncW-1:0] FUNC_TRAVERSE = 2'd2;

    localparam logic [StatW-1:0] ST_OK      = 2'd0;
    localparam logic [StatW-1:0] ST_FULL    = 2'd1;
    localparam logic [StatW-1:0] ST_BADADDR = 2'd2;
    localparam logic [StatW-1:0] ST_EMPTY   = 2'd3;

    typedef struct packed {
        logic             val_we;
        logic [NodeW-1:0] val_wa;
        logic [ValW-1:0]  val_wd;
        logic             prev_we;
        logic [NodeW-1:0] prev_wa;
        logic [NodeW-1:0] prev_wd;
        logic             next_we;
        logic [NodeW-1:0] next_wa;
        logic [NodeW-1:0] next_wd;
        logic             rd_en;
        logic [NodeW-1:0] val_ra;
        logic [NodeW-1:0] prev_ra;
        logic [NodeW-1:0] next_ra;
    } t_mem_req;

    typedef struct packed {
        logic [ValW-1:0]  val_rd;
        logic [NodeW-1:0] prev_rd;
        logic [NodeW-1:0] next_rd;
    } t_mem_rsp;

    typedef struct packed {
        logic [ValW-1:0]  value;
        logic [NodeW-1:0] node;
        logic [StatW-1:0] status;
        logic             last;
    } t_result;

endpackage

FILE: src/adll_store.sv
// ----------------------------------------------------------------------------
// Array doubly linked list node store
// Value, previous-link and next-link memories, each with one write port and
// one registered read port.
// ----------------------------------------------------------------------------
module adll_store #(
    parameter int POOL_DEPTH = adll_pkg::PoolDepthDef
) (
    input  logic                i_clk,
    input  adll_pkg::t_mem_req  i_req,
    output adll_pkg::t_mem_rsp  o_rsp
);

    localparam int AW = $clog2(POOL_DEPTH);

    logic [adll_pkg::ValW-1:0] mem_val  [POOL_DEPTH];
    logic [AW-1:0]             mem_prev [POOL_DEPTH];
    logic [AW-1:0]             mem_next [POOL_DEPTH];

    logic [adll_pkg::ValW-1:0] r_val_rd;
    logic [AW-1:0]             r_prev_rd;
    logic [AW-1:0]             r_next_rd;

    always_ff @(posedge i_clk) begin
        if (i_req.val_we) begin
            mem_val[i_req.val_wa[AW-1:0]] <= i_req.val_wd;
        end
        if (i_req.prev_we) begin
            mem_prev[i_req.prev_wa[AW-1:0]] <= i_req.prev_wd[AW-1:0];
        end
        if (i_req.next_we) begin
            mem_next[i_req.next_wa[AW-1:0]] <= i_req.next_wd[AW-1:0];
        end
        if (i_req.rd_en) begin
            r_val_rd  <= mem_val[i_req.val_ra[AW-1:0]];
            r_prev_rd <= mem_prev[i_req.prev_ra[AW-1:0]];
            r_next_rd <= mem_next[i_req.next_ra[AW-1:0]];
        end
    end

    assign o_rsp.val_rd  = r_val_rd;
    assign o_rsp.prev_rd = adll_pkg::NodeW'(r_prev_rd);
    assign o_rsp.next_rd = adll_pkg::NodeW'(r_next_rd);

endmodule

FILE: src/adll_seq.sv
// ----------------------------------------------------------------------------
// Array doubly linked list sequencer
// Checks each operation, drives the node store one step at a time, keeps the
// live flags and the free slot counter, and hands results to the output stage.
// ----------------------------------------------------------------------------
module adll_seq #(
    parameter int POOL_DEPTH = adll_pkg::PoolDepthDef
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [adll_pkg::FuncW-1:0]   i_func,
    input  logic [adll_pkg::NodeW-1:0]   i_node_addr,
    input  logic [adll_pkg::ValW-1:0]    i_value,
    output adll_pkg::t_mem_req           o_req,
    input  adll_pkg::t_mem_rsp           i_rsp,
    output logic                         o_res_valid,
    output adll_pkg::t_result            o_res,
    input  logic                         i_res_ready
);

    localparam int AW = $clog2(POOL_DEPTH);
    localparam int FW = $clog2(POOL_DEPTH + 1);
    localparam int NW = adll_pkg::NodeW;

    localparam logic [NW:0]   DepthN  = (NW + 1)'(POOL_DEPTH);
    localparam logic [FW-1:0] FreeMax = FW'(POOL_DEPTH);
    localparam logic [AW-1:0] CntMax  = AW'(POOL_DEPTH - 2);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_CHK      = 3'd1;
    localparam logic [2:0] S_INS_WR1  = 3'd2;
    localparam logic [2:0] S_INS_WR2  = 3'd3;
    localparam logic [2:0] S_ERA_WR   = 3'd4;
    localparam logic [2:0] S_TRV_HEAD = 3'd5;
    localparam logic [2:0] S_TRV_RD   = 3'd6;
    localparam logic [2:0] S_TRV_OUT  = 3'd7;

    logic [2:0]                 r_state, n_state;
    logic [POOL_DEPTH-1:0]      r_live, n_live;
    logic                       r_head_vld, n_head_vld;
    logic [FW-1:0]              r_free, n_free;
    logic [NW-1:0]              r_link, n_link;
    logic [AW-1:0]              r_cnt, n_cnt;
    logic [NW-1:0]              r_rd_node, n_rd_node;
    logic [adll_pkg::FuncW-1:0] r_func;
    logic [NW-1:0]              r_addr;
    logic [adll_pkg::ValW-1:0]  r_value;

    logic          addr_in;
    logic          addr_live;
    logic          next_vld;
    logic [NW-1:0] nxt;
    logic          fin;
    logic          pool_full;
    logic [NW-1:0] slot;

    assign o_ready   = (r_state == S_IDLE);
    assign addr_in   = {1'b0, r_addr} < DepthN;
    assign addr_live = addr_in && r_live[r_addr[AW-1:0]];
    assign next_vld  = (r_rd_node == '0) ? r_head_vld : r_live[r_rd_node[AW-1:0]];
    assign nxt       = next_vld ? i_rsp.next_rd : '0;
    assign fin       = (nxt == '0) || (r_cnt == CntMax);
    assign pool_full = r_free >= FreeMax;
    assign slot      = NW'(r_free);

    always_comb begin
        n_state     = r_state;
        n_live      = r_live;
        n_head_vld  = r_head_vld;
        n_free      = r_free;
        n_link      = r_link;
        n_cnt       = r_cnt;
        n_rd_node   = r_rd_node;
        o_req       = '0;
        o_res_valid = 1'b0;
        o_res       = '0;
        o_res.last  = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                o_req.rd_en = 1'b1;
                unique case (r_func)
                    adll_pkg::FUNC_INSERT: begin
                        o_req.next_ra = r_addr;
                        n_rd_node     = r_addr;
                        priority if (r_addr != '0 && !addr_live) begin
                            o_res_valid  = 1'b1;
                            o_res.status = adll_pkg::ST_BADADDR;
                            if (i_res_ready) begin
                                n_state = S_IDLE;
                            end
                        end else if (pool_full) begin
                            o_res_valid  = 1'b1;
                            o_res.status = adll_pkg::ST_FULL;
                            if (i_res_ready) begin
                                n_state = S_IDLE;
                            end
                        end else begin
                            n_state = S_INS_WR1;
                        end
                    end
                    adll_pkg::FUNC_ERASE: begin
                        o_req.prev_ra = r_addr;
                        o_req.next_ra = r_addr;
                        n_rd_node     = r_addr;
                        if (r_addr == '0 || !addr_live) begin
                            o_res_valid  = 1'b1;
                            o_res.node   = r_addr;
                            o_res.status = adll_pkg::ST_BADADDR;
                            if (i_res_ready) begin
                                n_state = S_IDLE;
                            end
                        end else begin
                            n_state = S_ERA_WR;
                        end
                    end
                    adll_pkg::FUNC_TRAVERSE: begin
                        o_req.next_ra = '0;
                        n_rd_node     = '0;
                        n_state       = S_TRV_HEAD;
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_INS_WR1: begin
                n_link        = nxt;
                o_req.val_we  = 1'b1;
                o_req.val_wa  = slot;
                o_req.val_wd  = r_value;
                o_req.prev_we = 1'b1;
                o_req.prev_wa = slot;
                o_req.prev_wd = r_addr;
                o_req.next_we = 1'b1;
                o_req.next_wa = slot;
                o_req.next_wd = nxt;
                n_live[r_free[AW-1:0]] = 1'b1;
                n_state       = S_INS_WR2;
            end
            S_INS_WR2: begin
                o_res_valid = 1'b1;
                o_res.node  = slot;
                if (i_res_ready) begin
                    if (r_link != '0) begin
                        o_req.prev_we = 1'b1;
                        o_req.prev_wa = r_link;
                        o_req.prev_wd = slot;
                    end
                    o_req.next_we = 1'b1;
                    o_req.next_wa = r_addr;
                    o_req.next_wd = slot;
                    if (r_addr == '0) begin
                        n_head_vld = 1'b1;
                    end
                    n_free  = r_free + FW'(1);
                    n_state = S_IDLE;
                end
            end
            S_ERA_WR: begin
                o_res_valid = 1'b1;
                o_res.node  = r_addr;
                if (i_res_ready) begin
                    o_req.next_we = 1'b1;
                    o_req.next_wa = i_rsp.prev_rd;
                    o_req.next_wd = nxt;
                    if (i_rsp.prev_rd == '0) begin
                        n_head_vld = 1'b1;
                    end
                    if (nxt != '0) begin
                        o_req.prev_we = 1'b1;
                        o_req.prev_wa = nxt;
                        o_req.prev_wd = i_rsp.prev_rd;
                    end
                    n_live[r_addr[AW-1:0]] = 1'b0;
                    n_state = S_IDLE;
                end
            end
            S_TRV_HEAD: begin
                if (nxt == '0) begin
                    o_res_valid  = 1'b1;
                    o_res.status = adll_pkg::ST_EMPTY;
                    if (i_res_ready) begin
                        n_state = S_IDLE;
                    end
                end else begin
                    n_link  = nxt;
                    n_cnt   = '0;
                    n_state = S_TRV_RD;
                end
            end
            S_TRV_RD: begin
                o_req.rd_en   = 1'b1;
                o_req.val_ra  = r_link;
                o_req.next_ra = r_link;
                n_rd_node     = r_link;
                n_state       = S_TRV_OUT;
            end
            S_TRV_OUT: begin
                o_res_valid = 1'b1;
                o_res.value = i_rsp.val_rd;
                o_res.node  = r_rd_node;
                o_res.last  = fin;
                if (i_res_ready) begin
                    if (fin) begin
                        n_state = S_IDLE;
                    end else begin
                        n_link  = nxt;
                        n_cnt   = r_cnt + AW'(1);
                        n_state = S_TRV_RD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_live     <= '0;
            r_head_vld <= 1'b0;
            r_free     <= FW'(1);
        end else begin
            r_state    <= n_state;
            r_live     <= n_live;
            r_head_vld <= n_head_vld;
            r_free     <= n_free;
        end
    end

    always_ff @(posedge i_clk) begin
        r_link    <= n_link;
        r_cnt     <= n_cnt;
        r_rd_node <= n_rd_node;
        if (i_valid && o_ready) begin
            r_func  <= i_func;
            r_addr  <= i_node_addr;
            r_value <= i_value;
        end
    end

`ifndef ASSERT_OFF
    a_idle_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !o_res_valid)
        else $error("Result offered while the sequencer is idle.");

    a_head_never_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_live[0])
        else $error("The head sentinel was marked as a live node.");

    a_free_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_free != '0) && (r_free <= FreeMax))
        else $error("Free slot counter left its range.");

    a_insert_bumps_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_INS_WR2 && i_res_ready) |=> (r_free == $past(r_free) + FW'(1)))
        else $error("Committed insert did not advance the free slot counter.");
`endif

endmodule

FILE: src/array_doubly_linked_list.sv
// ----------------------------------------------------------------------------
// Array doubly linked list
// Doubly linked list in fixed node memories with node 0 as head sentinel,
// supporting insert after a node, erase of a node and an in-order traverse.
// ----------------------------------------------------------------------------
// One item is worked at a time and the block is not ready meanwhile. An insert
// reads the next link of the given node, writes the new node and links it in
// as its result is taken; an erase reads both links and relinks the neighbours
// as its result is taken. A traverse reads the head link, then for each node
// makes one read of the value and link memories, then issues its result.
// Results leave through an output register, so the next item can be taken
// while the last result still waits. Erased slots are never reused; an insert
// once all POOL_DEPTH - 1 slots have been handed out reports a full pool.
// ----------------------------------------------------------------------------
module array_doubly_linked_list #(
    parameter int POOL_DEPTH = adll_pkg::PoolDepthDef
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [adll_pkg::FuncW-1:0]   i_func,
    input  logic [adll_pkg::NodeW-1:0]   i_node_addr,
    input  logic signed [adll_pkg::ValW-1:0] i_value,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic signed [adll_pkg::ValW-1:0] o_out_value,
    output logic [adll_pkg::NodeW-1:0]   o_out_node,
    output logic [adll_pkg::StatW-1:0]   o_status,
    output logic                         o_last
);

    adll_pkg::t_mem_req req;
    adll_pkg::t_mem_rsp rsp;
    adll_pkg::t_result  res;
    logic               res_valid;
    logic               res_ready;

    logic               r_out_vld;
    adll_pkg::t_result  r_out;

    adll_store #(
        .POOL_DEPTH (POOL_DEPTH)
    ) u_store (
        .i_clk (i_clk),
        .i_req (req),
        .o_rsp (rsp)
    );

    adll_seq #(
        .POOL_DEPTH (POOL_DEPTH)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_func      (i_func),
        .i_node_addr (i_node_addr),
        .i_value     (i_value),
        .o_req       (req),
        .i_rsp       (rsp),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_res_ready (res_ready)
    );

    assign res_ready = !r_out_vld || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (res_ready) begin
            r_out_vld <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) begin
            r_out <= res;
        end
    end

    assign o_valid     = r_out_vld;
    assign o_out_value = r_out.value;
    assign o_out_node  = r_out.node;
    assign o_status    = r_out.status;
    assign o_last      = r_out.last;

endmodule
